// ----- rtl/bmp24fb_pkg.sv -----
// Shared types and constants for the 24-bit BMP stream to frame-buffer unit.
// No dependencies; every other rtl file imports this package.
package bmp24fb_pkg;

    // Result kinds
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_EOF    = 2'd2;

    // Configuration register indexes
    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    // Register reset values
    localparam logic [11:0] SCREEN_W_RESET = 12'd640;
    localparam logic [11:0] SCREEN_H_RESET = 12'd480;

    // Header layout
    localparam logic [31:0] HDR_LAST_INDEX  = 32'd25;
    localparam logic [31:0] BPP_INDEX       = 32'd28;
    localparam logic [31:0] PIXEL_MIN_INDEX = 32'd29;
    localparam logic [7:0]  BPP_VALUE       = 8'd24;

    // Command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // One queued command: an optional pixel/reject result, then an optional end marker
    typedef struct packed {
        logic        has_first;
        logic        first_rej;
        logic        eof;
        logic [11:0] col;
        logic [11:0] row;
        logic [11:0] org_x;
        logic [11:0] org_y;
        logic [23:0] color;
    } bmp24fb_cmd_t;

endpackage

// ----- rtl/bmp24fb_front.sv -----
// Front end: takes file bytes, parses the BMP header and walks the pixel data.
// Pushes one command per byte that yields results. Depends on bmp24fb_pkg.
module bmp24fb_front
    import bmp24fb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [7:0]   file_byte,
    input  logic         file_end,
    output logic         in_stall,
    input  logic [11:0]  screen_width,
    input  logic [11:0]  screen_height,
    input  logic         q_full,
    output logic         q_push,
    output bmp24fb_cmd_t q_data
);

    logic [31:0] byte_index_reg, byte_index_next;
    logic [31:0] data_offset_reg, data_offset_next;
    logic [15:0] image_width_reg, image_width_next;
    logic [15:0] image_height_reg, image_height_next;
    logic [23:0] height_raw_reg, height_raw_next;
    logic        size_bad_reg, size_bad_next;
    logic        top_down_reg, top_down_next;
    logic        rejected_reg, rejected_next;
    logic [15:0] column_count_reg, column_count_next;
    logic [15:0] row_count_reg, row_count_next;
    logic [15:0] row_img_reg, row_img_next;
    logic [1:0]  byte_phase_reg, byte_phase_next;
    logic [15:0] partial_color_reg, partial_color_next;
    logic [1:0]  pad_count_reg, pad_count_next;
    logic [11:0] org_x_reg, org_y_reg;

    logic         accept;
    logic [31:0]  idx;
    logic [31:0]  height_full;
    logic [31:0]  height_mag;
    logic [15:0]  col_inc;
    logic [15:0]  row_img_step;
    bmp24fb_cmd_t cmd;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign idx      = byte_index_reg;

    assign height_full  = {file_byte, height_raw_reg};
    assign height_mag   = height_full[31] ? (~height_full + 32'd1) : height_full;
    assign col_inc      = column_count_reg + 16'd1;
    assign row_img_step = top_down_reg ? (row_img_reg + 16'd1) : (row_img_reg - 16'd1);

    // Centering origin, recomputed every cycle from the header and the screen size
    always_ff @(posedge clk)
    begin
        org_x_reg <= (image_width_reg < {4'd0, screen_width})
                     ? ((screen_width - image_width_reg[11:0]) >> 1) : 12'd0;
        org_y_reg <= (image_height_reg < {4'd0, screen_height})
                     ? ((screen_height - image_height_reg[11:0]) >> 1) : 12'd0;
    end

    // Byte classification and run state update
    always_comb
    begin
        byte_index_next    = byte_index_reg;
        data_offset_next   = data_offset_reg;
        image_width_next   = image_width_reg;
        image_height_next  = image_height_reg;
        height_raw_next    = height_raw_reg;
        size_bad_next      = size_bad_reg;
        top_down_next      = top_down_reg;
        rejected_next      = rejected_reg;
        column_count_next  = column_count_reg;
        row_count_next     = row_count_reg;
        row_img_next       = row_img_reg;
        byte_phase_next    = byte_phase_reg;
        partial_color_next = partial_color_reg;
        pad_count_next     = pad_count_reg;
        cmd                = '0;

        if (accept)
        begin
            if (idx <= HDR_LAST_INDEX)
            begin
                // little-endian header fields
                case (idx[4:0]) inside
                    5'd10: data_offset_next[7:0]   = file_byte;
                    5'd11: data_offset_next[15:8]  = file_byte;
                    5'd12: data_offset_next[23:16] = file_byte;
                    5'd13: data_offset_next[31:24] = file_byte;
                    5'd18: image_width_next[7:0]   = file_byte;
                    5'd19: image_width_next[15:8]  = file_byte;
                    [5'd20:5'd21]:
                    begin
                        if (file_byte != 8'd0)
                            size_bad_next = 1'b1;
                    end
                    5'd22: height_raw_next[7:0]    = file_byte;
                    5'd23: height_raw_next[15:8]   = file_byte;
                    5'd24: height_raw_next[23:16]  = file_byte;
                    5'd25:
                    begin
                        if (height_full[31])
                            top_down_next = 1'b1;
                        if (height_mag[31:16] != 16'd0)
                            size_bad_next = 1'b1;
                        else
                        begin
                            image_height_next = height_mag[15:0];
                            row_img_next      = height_full[31] ? 16'd0
                                                : (height_mag[15:0] - 16'd1);
                        end
                    end
                    default: ;
                endcase
            end
            else if (idx == BPP_INDEX)
            begin
                // format check
                if (file_byte != BPP_VALUE || size_bad_reg)
                begin
                    rejected_next = 1'b1;
                    cmd.has_first = 1'b1;
                    cmd.first_rej = 1'b1;
                end
            end
            else if (idx >= PIXEL_MIN_INDEX && idx >= data_offset_reg && !rejected_reg)
            begin
                // pixel data walk
                if (image_width_reg != 16'd0 && image_height_reg != 16'd0
                    && row_count_reg < image_height_reg)
                begin
                    if (column_count_reg < image_width_reg)
                    begin
                        case (byte_phase_reg)
                            2'd0:
                            begin
                                partial_color_next = {8'd0, file_byte};
                                byte_phase_next    = 2'd1;
                            end
                            2'd1:
                            begin
                                partial_color_next = {file_byte, partial_color_reg[7:0]};
                                byte_phase_next    = 2'd2;
                            end
                            default:
                            begin
                                if (column_count_reg < {4'd0, screen_width}
                                    && row_img_reg < {4'd0, screen_height})
                                begin
                                    cmd.has_first = 1'b1;
                                    cmd.col       = column_count_reg[11:0];
                                    cmd.row       = row_img_reg[11:0];
                                    cmd.org_x     = org_x_reg;
                                    cmd.org_y     = org_y_reg;
                                    cmd.color     = {file_byte, partial_color_reg};
                                end
                                byte_phase_next   = 2'd0;
                                column_count_next = col_inc;
                                if (col_inc == image_width_reg && image_width_reg[1:0] == 2'd0)
                                begin
                                    column_count_next = 16'd0;
                                    row_count_next    = row_count_reg + 16'd1;
                                    row_img_next      = row_img_step;
                                end
                            end
                        endcase
                    end
                    else
                    begin
                        // row padding
                        if (({1'b0, pad_count_reg} + 3'd1) >= {1'b0, image_width_reg[1:0]})
                        begin
                            pad_count_next    = 2'd0;
                            column_count_next = 16'd0;
                            row_count_next    = row_count_reg + 16'd1;
                            row_img_next      = row_img_step;
                        end
                        else
                            pad_count_next = pad_count_reg + 2'd1;
                    end
                end
            end

            if (idx != 32'hFFFF_FFFF)
                byte_index_next = idx + 32'd1;

            // end of file: short-file reject, end marker, then back to reset
            if (file_end)
            begin
                if (idx < BPP_INDEX && !rejected_reg)
                begin
                    cmd.has_first = 1'b1;
                    cmd.first_rej = 1'b1;
                end
                cmd.eof            = 1'b1;
                byte_index_next    = '0;
                data_offset_next   = '0;
                image_width_next   = '0;
                image_height_next  = '0;
                height_raw_next    = '0;
                size_bad_next      = 1'b0;
                top_down_next      = 1'b0;
                rejected_next      = 1'b0;
                column_count_next  = '0;
                row_count_next     = '0;
                row_img_next       = '0;
                byte_phase_next    = '0;
                partial_color_next = '0;
                pad_count_next     = '0;
            end
        end
    end

    assign q_push = accept && (cmd.has_first || cmd.eof);
    assign q_data = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg    <= '0;
            data_offset_reg   <= '0;
            image_width_reg   <= '0;
            image_height_reg  <= '0;
            height_raw_reg    <= '0;
            size_bad_reg      <= 1'b0;
            top_down_reg      <= 1'b0;
            rejected_reg      <= 1'b0;
            column_count_reg  <= '0;
            row_count_reg     <= '0;
            row_img_reg       <= '0;
            byte_phase_reg    <= '0;
            partial_color_reg <= '0;
            pad_count_reg     <= '0;
        end
        else
        begin
            byte_index_reg    <= byte_index_next;
            data_offset_reg   <= data_offset_next;
            image_width_reg   <= image_width_next;
            image_height_reg  <= image_height_next;
            height_raw_reg    <= height_raw_next;
            size_bad_reg      <= size_bad_next;
            top_down_reg      <= top_down_next;
            rejected_reg      <= rejected_next;
            column_count_reg  <= column_count_next;
            row_count_reg     <= row_count_next;
            row_img_reg       <= row_img_next;
            byte_phase_reg    <= byte_phase_next;
            partial_color_reg <= partial_color_next;
            pad_count_reg     <= pad_count_next;
        end
    end

`ifndef SYNTHESIS
    // the end byte always leaves the run state at reset
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && file_end) |=> (byte_index_reg == 32'd0 && !rejected_reg))
        else $error("front: run state not cleared after end of file");
`endif

endmodule

// ----- rtl/bmp24fb_queue.sv -----
// Short command queue between the front and back ends.
// Depends on bmp24fb_pkg for the command type and depth.
module bmp24fb_queue
    import bmp24fb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  bmp24fb_cmd_t push_data,
    output logic         full,
    input  logic         pop,
    output bmp24fb_cmd_t head,
    output logic         empty
);

    bmp24fb_cmd_t     mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [Q_CW-1:0]  count_reg;

    assign full  = (count_reg == Q_CW'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            if (push && !pop)
                count_reg <= count_reg + Q_CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - Q_CW'(1);
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("queue: push while full");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue: pop while empty");
`endif

endmodule

// ----- rtl/bmp24fb_back.sv -----
// Back end: expands queued commands into results and holds the output register.
// Depends on bmp24fb_pkg.
module bmp24fb_back
    import bmp24fb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  bmp24fb_cmd_t head,
    input  logic         q_empty,
    output logic         q_pop,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [1:0]   kind,
    output logic [11:0]  pos_x,
    output logic [11:0]  pos_y,
    output logic [23:0]  color,
    output logic         last_result
);

    logic        valid_reg, valid_next;
    logic        sub_reg, sub_next;
    logic [1:0]  kind_reg, kind_next;
    logic [11:0] x_reg, x_next;
    logic [11:0] y_reg, y_next;
    logic [23:0] color_reg, color_next;
    logic        last_reg, last_next;
    logic        load;

    assign load = !valid_reg || !out_stall;

    // pick the next result of the head command
    always_comb
    begin
        valid_next = valid_reg && out_stall;
        sub_next   = sub_reg;
        kind_next  = kind_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        color_next = color_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;

        if (load && !q_empty)
        begin
            valid_next = 1'b1;
            if (head.has_first && !sub_reg)
            begin
                last_next = 1'b0;
                if (head.first_rej)
                begin
                    kind_next  = KIND_REJECT;
                    x_next     = '0;
                    y_next     = '0;
                    color_next = '0;
                end
                else
                begin
                    kind_next  = KIND_PIXEL;
                    x_next     = head.org_x + head.col;
                    y_next     = head.org_y + head.row;
                    color_next = head.color;
                end
                if (head.eof)
                    sub_next = 1'b1;
                else
                    q_pop = 1'b1;
            end
            else
            begin
                kind_next  = KIND_EOF;
                x_next     = '0;
                y_next     = '0;
                color_next = '0;
                last_next  = 1'b1;
                sub_next   = 1'b0;
                q_pop      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sub_reg   <= sub_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        color_reg <= color_next;
        last_reg  <= last_next;
    end

    assign out_valid   = valid_reg;
    assign kind        = kind_reg;
    assign pos_x       = x_reg;
    assign pos_y       = y_reg;
    assign color       = color_reg;
    assign last_result = last_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (last_reg == (kind_reg == KIND_EOF)))
        else $error("back: last flag does not match end-of-file kind");
`endif

endmodule

// ----- rtl/bmp24_stream_to_framebuffer_unit.sv -----
// Top level of the 24-bit BMP stream to frame-buffer unit: configuration
// registers, front end, command queue and back end. Depends on bmp24fb_pkg.
//
// Takes one file byte per clock unless in_stall is raised and produces pixel
// writes (x, y, color), a reject result for a bad or truncated header and an
// end-of-file result on the byte flagged as last. The front end parses and
// classifies each byte and pushes a command into a 4-entry queue; the back end
// turns each command into results through a registered output, one result per
// clock while out_stall is low. A byte yields at most one result except the
// final byte, which can add a second (the end marker), so sustained input rate
// is one byte per clock when nothing stalls. The user must write the screen
// size only between files; the block itself does not enforce it.
module bmp24_stream_to_framebuffer_unit
    import bmp24fb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  file_byte,
    input  logic        file_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [11:0] pos_x,
    output logic [11:0] pos_y,
    output logic [23:0] color,
    output logic        last_result
);

    logic [11:0]  screen_width_reg, screen_height_reg;
    logic         q_full, q_empty, q_push, q_pop;
    bmp24fb_cmd_t q_data, q_head;

    // screen size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_W_RESET;
            screen_height_reg <= SCREEN_H_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    bmp24fb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .file_byte     (file_byte),
        .file_end      (file_end),
        .in_stall      (in_stall),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_data)
    );

    bmp24fb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    bmp24fb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .color       (color),
        .last_result (last_result)
    );

endmodule
